[rtl/assert_macros.svh]
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, skipped while reset is asserted.
`define LMBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lmbs assertion failed");

// Check a property on every rising clock edge, reset included.
`define LMBS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lmbs assertion failed");

`endif

[rtl/lmbs_pkg.sv]
// Types and constants of the logistic map bar selector.
// No dependencies; imported by every module of the block.
package lmbs_pkg;

    localparam int X_W     = 25;   // Q1.24 map value, 0 to 1.0 inclusive
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 35;

    // Largest bar count; the 4-bit bar index and 5-bit bar count ports fix it
    localparam int MAX_BARS = 16;

    localparam logic [X_W-1:0] ONE_Q24  = 25'd16777216;
    localparam logic [X_W-1:0] NEAR_Q24 = 25'd16775538;  // 0.9999
    localparam logic [16:0]    ONE_Q16  = 17'd65536;
    localparam logic [17:0]    FLASH_MAX = 18'd262143;

    // Register reset values
    localparam logic [24:0] GAIN_RST   = 25'd16567501;
    localparam logic [5:0]  ROUNDS_RST = 6'd6;
    localparam logic [20:0] RATE_RST   = 21'd32768;
    localparam logic [16:0] FLOOR_RST  = 17'd6554;
    localparam logic [16:0] CEIL_RST   = 17'd58982;
    localparam logic [4:0]  BARS_RST   = 5'd4;
    localparam logic [17:0] BASE_RST   = 18'd65536;
    localparam logic [17:0] OFFSET_RST = 18'd0;

    typedef enum logic [2:0] {
        REG_MAP_GAIN     = 3'd0,
        REG_ROUND_COUNT  = 3'd1,
        REG_SWEEP_RATE   = 3'd2,
        REG_SEED_FLOOR   = 3'd3,
        REG_SEED_CEILING = 3'd4,
        REG_BARS_IN_USE  = 3'd5,
        REG_BASE_LEVEL   = 3'd6,
        REG_LEVEL_OFFSET = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PHASE,
        S_TRI,
        S_SEED_LO,
        S_SEED_HI,
        S_SEED_SUM,
        S_ROUND_A,
        S_ROUND_B,
        S_ROUND_C,
        S_BAR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        MS_PHASE,
        MS_SEED_LO,
        MS_SEED_HI,
        MS_ROUND_A,
        MS_ROUND_B,
        MS_BAR
    } mul_sel_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     time_add;   // add time_step to elapsed time
        logic     tri_load;   // capture triangle wave from phase product
        logic     acc_load;   // capture lower seed product
        logic     x_seed;     // load x from seed sum
        logic     x_round;    // load x from gain product
        logic     x_final;    // clamp x below one
    } lmbs_cmd_t;

endpackage

[rtl/lmbs_ctrl.sv]
// Sequencer of the logistic map bar selector.
// Depends on lmbs_pkg; drives lmbs_dp through lmbs_cmd_t.
module lmbs_ctrl
    import lmbs_pkg::*;
#(
    parameter int CNT_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             kind,
    input  logic             out_free,
    input  logic [CNT_W-1:0] rounds_eff,
    output logic             in_ready,
    output logic             out_load,
    output lmbs_cmd_t        cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        out_load     = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = MS_PHASE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind)
                        state_next = S_PHASE;
                    else
                        cmd.time_add = 1'b1;
                end
            end
            S_PHASE:
            begin
                cmd.mul_sel = MS_PHASE;
                state_next  = S_TRI;
            end
            S_TRI:
            begin
                cmd.tri_load = 1'b1;
                state_next   = S_SEED_LO;
            end
            S_SEED_LO:
            begin
                cmd.mul_sel = MS_SEED_LO;
                state_next  = S_SEED_HI;
            end
            S_SEED_HI:
            begin
                cmd.mul_sel  = MS_SEED_HI;
                cmd.acc_load = 1'b1;
                state_next   = S_SEED_SUM;
            end
            S_SEED_SUM:
            begin
                cmd.x_seed = 1'b1;
                cnt_next   = rounds_eff;
                state_next = S_ROUND_A;
            end
            S_ROUND_A:
            begin
                cmd.mul_sel = MS_ROUND_A;
                state_next  = S_ROUND_B;
            end
            S_ROUND_B:
            begin
                cmd.mul_sel = MS_ROUND_B;
                state_next  = S_ROUND_C;
            end
            S_ROUND_C:
            begin
                cmd.x_round = 1'b1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg <= CNT_W'(1))
                    state_next = S_BAR;
                else
                    state_next = S_ROUND_A;
            end
            S_BAR:
            begin
                cmd.mul_sel = MS_BAR;
                cmd.x_final = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // keep the bar product in the multiplier register while waiting,
                // and hold until the output register can take the result
                cmd.mul_sel = MS_BAR;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/lmbs_dp.sv]
// Datapath of the logistic map bar selector: time accumulator, shared multiplier, map value.
// Depends on lmbs_pkg; commanded by lmbs_ctrl.
module lmbs_dp
    import lmbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lmbs_cmd_t   cmd,
    input  logic [15:0] time_step,
    input  logic [24:0] map_gain,
    input  logic [20:0] sweep_rate,
    input  logic [16:0] seed_floor,
    input  logic [16:0] seed_ceiling,
    input  logic [4:0]  bars_eff,
    output logic [4:0]  bar_idx,
    output logic [23:0] x_value
);

    logic [47:0]        elapsed_reg;
    logic [MUL_P_W-1:0] mul_reg;
    logic [16:0]        tri_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [X_W-1:0]     x_reg, x_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [15:0]        phase;
    logic [16:0]        t2;
    logic [16:0]        tri_wave;
    logic [ACC_W:0]     seed_sum;
    logic [27:0]        seed_x;
    logic [34:0]        round_x;
    logic [X_W-1:0]     x_clamped;
    logic [4:0]         bar_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            elapsed_reg <= '0;
        else if (cmd.time_add)
            elapsed_reg <= elapsed_reg + {32'd0, time_step};
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MS_PHASE:
            begin
                mul_a = elapsed_reg[31:0];
                mul_b = {4'd0, sweep_rate};
            end
            MS_SEED_LO:
            begin
                mul_a = MUL_A_W'(seed_floor);
                mul_b = MUL_B_W'(ONE_Q16 - tri_reg);
            end
            MS_SEED_HI:
            begin
                mul_a = MUL_A_W'(seed_ceiling);
                mul_b = MUL_B_W'(tri_reg);
            end
            MS_ROUND_A:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = ONE_Q24 - x_reg;
            end
            MS_ROUND_B:
            begin
                mul_a = MUL_A_W'(map_gain);
                mul_b = mul_reg[48:24];
            end
            MS_BAR:
            begin
                mul_a = MUL_A_W'(x_clamped);
                mul_b = MUL_B_W'(bars_eff);
            end
            default:
            begin
                mul_a = elapsed_reg[31:0];
                mul_b = {4'd0, sweep_rate};
            end
        endcase
    end

    // Triangle wave |2p - 1| from the Q0.16 phase
    assign phase    = mul_reg[31:16];
    assign t2       = {phase, 1'b0};
    assign tri_wave = t2[16] ? {1'b0, t2[15:0]} : (ONE_Q16 - t2);

    assign seed_sum  = {1'b0, acc_reg} + {1'b0, mul_reg[ACC_W-1:0]};
    assign seed_x    = seed_sum[ACC_W:8];
    assign round_x   = mul_reg[56:22];
    assign x_clamped = (x_reg >= ONE_Q24) ? NEAR_Q24 : x_reg;

    always_comb
    begin
        x_next = x_reg;
        if (cmd.x_seed)
            x_next = (seed_x > 28'(ONE_Q24)) ? ONE_Q24 : seed_x[X_W-1:0];
        else if (cmd.x_round)
            x_next = (round_x > 35'(ONE_Q24)) ? ONE_Q24 : round_x[X_W-1:0];
        else if (cmd.x_final)
            x_next = x_clamped;
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        x_reg   <= x_next;
        if (cmd.tri_load)
            tri_reg <= tri_wave;
        if (cmd.acc_load)
            acc_reg <= mul_reg[ACC_W-1:0];
    end

    // x is below one here, so the bar product stays under 2^29
    assign bar_raw = mul_reg[28:24];
    assign bar_idx = (bar_raw >= bars_eff) ? (bars_eff - 5'd1) : bar_raw;
    assign x_value = x_reg[23:0];

endmodule

[rtl/logistic_map_bar_selector.sv]
// Top level of the logistic map bar selector: registers, output stage, controller and datapath.
// Depends on lmbs_pkg, lmbs_ctrl and lmbs_dp.
//
// Usage:
//   Input channel (in_valid/in_ready, kind, time_step): kind 0 is a tick that adds
//   time_step (Q0.16 s) to a wrapping Q32.16 elapsed-time accumulator and yields no
//   result; kind 1 is a frame request that yields exactly one result.
//   Output channel (out_valid/out_ready): chosen_bar, bar_total, map_value, flash_level.
//   Register port (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready; write
//   only while no frame is in flight.
// Sequence, with R the round count clamped to 1..MAX_ROUNDS:
//   A tick leaves the block ready for more input. A frame runs through the states
//   PHASE, TRI, SEED_LO, SEED_HI, SEED_SUM, R rounds of ROUND_A, ROUND_B and ROUND_C,
//   then BAR and DONE; one shared 32x25 multiplier runs phase, two seed products,
//   two products per map round and the bar product. No input is taken until the
//   frame's result is loaded. The reset round count is 6.
// Stall: a finished result sits in the output register; the block keeps taking
//   ticks and starts the next frame meanwhile, and holds that frame's result in the
//   datapath until the output register is free.
// Reset: registers return to their default values, elapsed time clears, the output
//   register empties and the block is ready for input at once.
module logistic_map_bar_selector
    import lmbs_pkg::*;
#(
    parameter int MAX_ROUNDS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] time_step,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  chosen_bar,
    output logic [4:0]  bar_total,
    output logic [23:0] map_value,
    output logic [17:0] flash_level,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [24:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

    logic [24:0] map_gain_reg;
    logic [5:0]  round_count_reg;
    logic [20:0] sweep_rate_reg;
    logic [16:0] seed_floor_reg;
    logic [16:0] seed_ceiling_reg;
    logic [4:0]  bars_in_use_reg;
    logic [17:0] base_level_reg;
    logic [17:0] level_offset_reg;

    logic             out_valid_reg;
    logic [3:0]       chosen_bar_reg;
    logic [4:0]       bar_total_reg;
    logic [23:0]      map_value_reg;
    logic [17:0]      flash_level_reg;

    logic [CNT_W-1:0] rounds_eff;
    logic [4:0]       bars_eff;
    logic signed [19:0] flash_sum;
    logic [17:0]      flash_sat;
    logic             out_free;
    logic             out_load;
    lmbs_cmd_t        cmd;
    logic [4:0]       bar_idx;
    logic [23:0]      x_value;

    // Register file; the port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_gain_reg     <= GAIN_RST;
            round_count_reg  <= ROUNDS_RST;
            sweep_rate_reg   <= RATE_RST;
            seed_floor_reg   <= FLOOR_RST;
            seed_ceiling_reg <= CEIL_RST;
            bars_in_use_reg  <= BARS_RST;
            base_level_reg   <= BASE_RST;
            level_offset_reg <= OFFSET_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_MAP_GAIN:     map_gain_reg     <= cfg_data;
                REG_ROUND_COUNT:  round_count_reg  <= cfg_data[5:0];
                REG_SWEEP_RATE:   sweep_rate_reg   <= cfg_data[20:0];
                REG_SEED_FLOOR:   seed_floor_reg   <= cfg_data[16:0];
                REG_SEED_CEILING: seed_ceiling_reg <= cfg_data[16:0];
                REG_BARS_IN_USE:  bars_in_use_reg  <= cfg_data[4:0];
                REG_BASE_LEVEL:   base_level_reg   <= cfg_data[17:0];
                REG_LEVEL_OFFSET: level_offset_reg <= cfg_data[17:0];
                default:          map_gain_reg     <= map_gain_reg;
            endcase
        end
    end

    // Clamp round and bar counts into their legal ranges; zero counts as one
    always_comb
    begin
        if (round_count_reg == 6'd0)
            rounds_eff = CNT_W'(1);
        else if (32'(round_count_reg) > MAX_ROUNDS)
            rounds_eff = CNT_W'(MAX_ROUNDS);
        else
            rounds_eff = CNT_W'(round_count_reg);

        if (bars_in_use_reg == 5'd0)
            bars_eff = 5'd1;
        else if (32'(bars_in_use_reg) > MAX_BARS)
            bars_eff = 5'(MAX_BARS);
        else
            bars_eff = bars_in_use_reg;
    end

    // Flash intensity: base plus signed offset, saturated to the 18-bit range
    assign flash_sum = signed'({2'b00, base_level_reg})
                     + signed'({{2{level_offset_reg[17]}}, level_offset_reg});
    assign flash_sat = flash_sum[19]         ? 18'd0 :
                       (flash_sum[18] != 1'b0) ? FLASH_MAX : flash_sum[17:0];

    assign out_free = !out_valid_reg || out_ready;

    lmbs_ctrl #(
        .CNT_W(CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .kind       (kind),
        .out_free   (out_free),
        .rounds_eff (rounds_eff),
        .in_ready   (in_ready),
        .out_load   (out_load),
        .cmd        (cmd)
    );

    lmbs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .time_step    (time_step),
        .map_gain     (map_gain_reg),
        .sweep_rate   (sweep_rate_reg),
        .seed_floor   (seed_floor_reg),
        .seed_ceiling (seed_ceiling_reg),
        .bars_eff     (bars_eff),
        .bar_idx      (bar_idx),
        .x_value      (x_value)
    );

    // Output register: fill on load, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            chosen_bar_reg  <= bar_idx[3:0];
            bar_total_reg   <= bars_eff;
            map_value_reg   <= x_value;
            flash_level_reg <= flash_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign chosen_bar  = chosen_bar_reg;
    assign bar_total   = bar_total_reg;
    assign map_value   = map_value_reg;
    assign flash_level = flash_level_reg;

endmodule

[rtl/lmbs_checker.sv]
// Port-level checks of the logistic map bar selector, bound to its top level.
// Depends on assert_macros.svh and logistic_map_bar_selector.
`include "assert_macros.svh"

module lmbs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  chosen_bar,
    input logic [4:0]  bar_total,
    input logic [23:0] map_value,
    input logic [17:0] flash_level
);

    // A stalled result holds
    `LMBS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable({chosen_bar, bar_total, map_value, flash_level}))

    // The lit bar lies inside the bar count and the count is never zero
    `LMBS_ASSERT(a_bar_range, clk, rst_n, out_valid |-> ({1'b0, chosen_bar} < bar_total) && (bar_total != 5'd0))

    // A frame occupies the block for the following cycle
    `LMBS_ASSERT(a_frame_busy, clk, rst_n, in_valid && in_ready && kind |=> !in_ready)

    // Reset leaves no result showing
    `LMBS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind logistic_map_bar_selector lmbs_checker u_lmbs_checker (.*);
